// ===== sv/hhcn_pkg.sv =====
// Package for the gate update block: sizes, shared types, and the sigmoid table.
// It has no dependencies; the modules refer to it by scoped names.
package hhcn_pkg;

  localparam int COMPARTMENTS = 256;
  localparam int COMP_AW = $clog2(COMPARTMENTS);
  localparam int SIG_DEPTH = 1024;
  localparam int SIG_AW = $clog2(SIG_DEPTH);
  localparam int SIG_HALF = SIG_DEPTH / 2;
  localparam int CFG_DW = 17;
  localparam int CFG_AW = 2;

  localparam int DIV_NW = 34;
  localparam int DIV_DW = 20;
  localparam int DIV_QW = 18;
  localparam int DIV_RW = DIV_DW + 1;
  localparam int DIV_BPC = 2;
  localparam int DIV_STEPS = DIV_QW / DIV_BPC;
  localparam int DIV_CW = $clog2(DIV_STEPS);

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);

  typedef enum logic [CFG_AW-1:0] {
    CFG_VHALF = 2'd0,
    CFG_SLOPE = 2'd1,
    CFG_EREV  = 2'd2,
    CFG_RATIO = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic signed [15:0] vhalf;
    logic [14:0]        slope;
    logic signed [16:0] erev;
    logic [15:0]        ratio;
  } cfg_t;

  typedef struct packed {
    logic               cmd;
    logic [7:0]         comp;
    logic signed [15:0] v;
    logic [15:0]        gbar;
    logic [15:0]        minf;
  } job_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_QW-1:0] quot;
    logic              rem_nz;
  } div_rsp_t;

  typedef logic [15:0] sig_rom_t [SIG_DEPTH];

  function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] exp_frac(logic [63:0] f);
    logic [63:0]        term;
    logic signed [63:0] sum;
    term = 64'd1 << 32;
    sum = $signed(term);
    for (int K = 1; K <= 20; K++) begin
      term = udiv64((term * f) >> 32, 64'(K));
      if (K % 2 == 1) sum = sum - $signed(term);
      else sum = sum + $signed(term);
    end
    return sum;
  endfunction

  function automatic sig_rom_t gen_sig_rom();
    sig_rom_t           rom;
    logic [63:0]        e1;
    logic [63:0]        e;
    logic [63:0]        m;
    logic [63:0]        n;
    logic [63:0]        f;
    logic [63:0]        den;
    logic signed [63:0] c;
    e1 = exp_frac(64'hFFFF_FFFF);
    for (int i = 0; i < SIG_DEPTH; i++) begin
      c = 64'(2 * i + 1 - 2 * SIG_HALF);
      m = (c < 0) ? -c : c;
      n = (64'd16 * m) / SIG_DEPTH;
      f = (((64'd16 * m) % SIG_DEPTH) << 32) / SIG_DEPTH;
      e = exp_frac(f);
      for (int j = 0; j < 16; j++) begin
        if (64'(j) < n) e = (e * e1) >> 32;
      end
      den = (64'd1 << 32) + e;
      if (c > 0) rom[i] = 16'(udiv64((64'd1 << 47) + den / 2, den));
      else rom[i] = 16'(udiv64((e << 15) + den / 2, den));
    end
    return rom;
  endfunction

  localparam sig_rom_t SIG_ROM = gen_sig_rom();

endpackage

// ===== sv/hhcn_in_if.sv =====
// Input channel: one command word with its valid/ready handshake.
// Depends on nothing.
interface hhcn_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic [7:0]         compartment;
  logic signed [15:0] membrane_voltage;
  logic [15:0]        peak_conductance;
  modport source(output valid, command, compartment, membrane_voltage, peak_conductance,
                 input ready);
  modport sink(input valid, command, compartment, membrane_voltage, peak_conductance,
               output ready);
endinterface

// ===== sv/hhcn_out_if.sv =====
// Output channel: one result word with its valid/ready handshake.
// Depends on nothing.
interface hhcn_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         compartment_out;
  logic [15:0]        gate_value;
  logic [15:0]        conductance;
  logic signed [31:0] channel_current;
  modport source(output valid, compartment_out, gate_value, conductance, channel_current,
                 input ready);
  modport sink(input valid, compartment_out, gate_value, conductance, channel_current,
               output ready);
endinterface

// ===== sv/hh_gate_crank_nicolson_update.sv =====
// Top level of the calcium gate update block: configuration registers and the two halves.
// Depends on hhcn_pkg, hhcn_in_if, hhcn_out_if, hhcn_front, hhcn_fifo and hhcn_back.
//
//   channel   dir  word
//   in_chan   in   command, compartment, membrane_voltage, peak_conductance
//   out_chan  out  compartment_out, gate_value, conductance, channel_current
//   cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i
//
// The front end takes a new word only once the last one has been pushed, bounded by its index divider.
// The back end runs a step through its update divider and skips the divider for an initialize;
// a two-word queue lets the halves stall apart.
// Reset clears control state only; the gate and conductance stores start undefined.
// A finished result waits in the output register while the back end takes the next word.
module hh_gate_crank_nicolson_update (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  hhcn_in_if.sink                       in_chan,
  hhcn_out_if.source                    out_chan,
  input  logic                          cfg_we_i,
  input  logic [hhcn_pkg::CFG_AW-1:0]   cfg_idx_i,
  input  logic [hhcn_pkg::CFG_DW-1:0]   cfg_data_i
);

  hhcn_pkg::cfg_t  cfg_q;
  hhcn_pkg::job_t  push_job, pop_job;
  logic            push_valid, push_ready, pop_valid, pop_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.vhalf <= -16'sd5120;
      cfg_q.slope <= 15'd1792;
      cfg_q.erev <= 17'sd33280;
      cfg_q.ratio <= 16'd4096;
    end else if (cfg_we_i) begin
      unique case (hhcn_pkg::cfg_idx_e'(cfg_idx_i))
        hhcn_pkg::CFG_VHALF: cfg_q.vhalf <= cfg_data_i[15:0];
        hhcn_pkg::CFG_SLOPE: cfg_q.slope <= cfg_data_i[14:0];
        hhcn_pkg::CFG_EREV:  cfg_q.erev <= cfg_data_i;
        hhcn_pkg::CFG_RATIO: cfg_q.ratio <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  hhcn_front u_front (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .in_chan,
    .push_valid_o(push_valid), .push_ready_i(push_ready), .push_job_o(push_job)
  );

  hhcn_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_valid_i(push_valid), .push_ready_o(push_ready), .push_job_i(push_job),
    .pop_valid_o(pop_valid), .pop_ready_i(pop_ready), .pop_job_o(pop_job)
  );

  hhcn_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .pop_valid_i(pop_valid), .pop_ready_o(pop_ready), .pop_job_i(pop_job), .out_chan
  );

  a_front_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_chan.valid && in_chan.ready |=> !in_chan.ready)
    else $error("front end took a word while busy");

  a_gate_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_chan.valid |-> out_chan.gate_value <= 16'd32768)
    else $error("gate value above one");

  a_zero_cond: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_chan.valid && out_chan.conductance == 16'd0 |-> out_chan.channel_current == 32'sd0)
    else $error("current without conductance");

endmodule

// ===== sv/hhcn_div.sv =====
// Restoring divider, two quotient bits per cycle, quotient known to fit DIV_QW bits.
// Depends on hhcn_pkg.
module hhcn_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hhcn_pkg::div_req_t  req_i,
  output hhcn_pkg::div_rsp_t  rsp_o
);

  logic                          busy_q;
  logic                          done_q;
  logic [hhcn_pkg::DIV_CW-1:0]   cnt_q;
  logic [hhcn_pkg::DIV_RW-1:0]   r_q, r_d;
  logic [hhcn_pkg::DIV_QW-1:0]   nq_q, nq_d;
  logic [hhcn_pkg::DIV_DW-1:0]   d_q;

  always_comb begin
    r_d = r_q;
    nq_d = nq_q;
    for (int b = 0; b < hhcn_pkg::DIV_BPC; b++) begin
      r_d = {r_d[hhcn_pkg::DIV_RW-2:0], nq_d[hhcn_pkg::DIV_QW-1]};
      nq_d = {nq_d[hhcn_pkg::DIV_QW-2:0], 1'b0};
      if (r_d >= {1'b0, d_q}) begin
        r_d = r_d - {1'b0, d_q};
        nq_d[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == hhcn_pkg::DIV_CW'(hhcn_pkg::DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      r_q <= hhcn_pkg::DIV_RW'(req_i.dividend[hhcn_pkg::DIV_NW-1:hhcn_pkg::DIV_QW]);
      nq_q <= req_i.dividend[hhcn_pkg::DIV_QW-1:0];
      d_q <= req_i.divisor;
    end else if (busy_q) begin
      r_q <= r_d;
      nq_q <= nq_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = nq_q;
  assign rsp_o.rem_nz = |r_q;

endmodule

// ===== sv/hhcn_front.sv =====
// Front end: accepts a command word, finds the sigmoid table index, reads the table.
// Depends on hhcn_pkg, hhcn_in_if and hhcn_div.
module hhcn_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hhcn_pkg::cfg_t    cfg_i,
  hhcn_in_if.sink           in_chan,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output hhcn_pkg::job_t    push_job_o
);

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_CHK  = 5'b00010,
    F_DIV  = 5'b00100,
    F_ROM  = 5'b01000,
    F_PUSH = 5'b10000
  } fstate_e;

  fstate_e                          state_q, state_d;
  hhcn_pkg::job_t                   job_q;
  logic signed [16:0]               diff_q;
  logic                             sat_q;
  logic [hhcn_pkg::SIG_AW-1:0]      idx_q, idx_d;
  logic [16:0]                      absd;
  logic [14:0]                      slope;
  logic [hhcn_pkg::DIV_NW-1:0]      num;
  logic [hhcn_pkg::DIV_DW-1:0]      den;
  logic [hhcn_pkg::DIV_QW:0]        qpos;
  logic [hhcn_pkg::DIV_QW:0]        qceil;
  hhcn_pkg::div_req_t               req;
  hhcn_pkg::div_rsp_t               rsp;

  hhcn_div u_div (.clk_i, .rst_ni, .req_i(req), .rsp_o(rsp));

  assign absd = diff_q[16] ? 17'(-diff_q) : 17'(diff_q);
  assign slope = (cfg_i.slope == '0) ? 15'd1 : cfg_i.slope;
  assign num = hhcn_pkg::DIV_NW'(absd) * hhcn_pkg::DIV_NW'(hhcn_pkg::SIG_DEPTH);
  assign den = hhcn_pkg::DIV_DW'({slope, 5'b0});
  assign req.start = (state_q == F_CHK);
  assign req.dividend = num;
  assign req.divisor = den;

  assign qpos = {1'b0, rsp.quot} + (hhcn_pkg::DIV_QW + 1)'(hhcn_pkg::SIG_HALF);
  assign qceil = {1'b0, rsp.quot} + {{hhcn_pkg::DIV_QW{1'b0}}, rsp.rem_nz};

  always_comb begin
    if (!diff_q[16]) begin
      if (sat_q || qpos > (hhcn_pkg::DIV_QW + 1)'(hhcn_pkg::SIG_DEPTH - 1))
        idx_d = hhcn_pkg::SIG_AW'(hhcn_pkg::SIG_DEPTH - 1);
      else
        idx_d = qpos[hhcn_pkg::SIG_AW-1:0];
    end else begin
      if (sat_q) idx_d = '0;
      else idx_d = hhcn_pkg::SIG_AW'((hhcn_pkg::DIV_QW + 1)'(hhcn_pkg::SIG_HALF) - qceil);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE: if (in_chan.valid) state_d = F_CHK;
      F_CHK:  state_d = F_DIV;
      F_DIV:  if (rsp.done) state_d = F_ROM;
      F_ROM:  state_d = F_PUSH;
      F_PUSH: if (push_ready_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= F_IDLE;
    else state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && in_chan.valid) begin
      job_q.cmd <= in_chan.command;
      job_q.comp <= in_chan.compartment;
      job_q.v <= in_chan.membrane_voltage;
      job_q.gbar <= in_chan.peak_conductance;
      diff_q <= 17'(in_chan.membrane_voltage) - 17'(cfg_i.vhalf);
    end
    if (state_q == F_CHK)
      sat_q <= num >= hhcn_pkg::DIV_NW'(den) * hhcn_pkg::DIV_NW'(hhcn_pkg::SIG_HALF);
    if (state_q == F_DIV && rsp.done) idx_q <= idx_d;
    if (state_q == F_ROM) job_q.minf <= hhcn_pkg::SIG_ROM[idx_q];
  end

  assign in_chan.ready = (state_q == F_IDLE);
  assign push_valid_o = (state_q == F_PUSH);
  assign push_job_o = job_q;

endmodule

// ===== sv/hhcn_fifo.sv =====
// Two-entry queue of classified words between the front and back ends.
// Depends on hhcn_pkg.
module hhcn_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  hhcn_pkg::job_t  push_job_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output hhcn_pkg::job_t  pop_job_o
);

  hhcn_pkg::job_t               mem_q [hhcn_pkg::FIFO_DEPTH];
  logic [hhcn_pkg::FIFO_AW-1:0] wp_q, rp_q;
  logic [hhcn_pkg::FIFO_AW:0]   cnt_q;
  logic                         push, pop;

  assign push_ready_o = (cnt_q != (hhcn_pkg::FIFO_AW + 1)'(hhcn_pkg::FIFO_DEPTH));
  assign pop_valid_o = (cnt_q != '0);
  assign push = push_valid_i && push_ready_o;
  assign pop = pop_valid_o && pop_ready_i;
  assign pop_job_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + 1'b1;
      if (pop) rp_q <= rp_q + 1'b1;
      if (push && !pop) cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= push_job_i;
  end

endmodule

// ===== sv/hhcn_back.sv =====
// Back end: gate and conductance stores, the update division, current and saturation.
// Depends on hhcn_pkg, hhcn_out_if and hhcn_div.
module hhcn_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  hhcn_pkg::cfg_t  cfg_i,
  input  logic            pop_valid_i,
  output logic            pop_ready_o,
  input  hhcn_pkg::job_t  pop_job_i,
  hhcn_out_if.source      out_chan
);

  typedef enum logic [6:0] {
    B_IDLE  = 7'b0000001,
    B_RD    = 7'b0000010,
    B_SUM   = 7'b0000100,
    B_DIV   = 7'b0001000,
    B_CLAMP = 7'b0010000,
    B_MUL   = 7'b0100000,
    B_SAT   = 7'b1000000
  } bstate_e;

  bstate_e                     state_q, state_d;
  hhcn_pkg::job_t              job_q;
  logic [15:0]                 gate_mem [hhcn_pkg::COMPARTMENTS];
  logic [15:0]                 gbar_mem [hhcn_pkg::COMPARTMENTS];
  logic [15:0]                 gate_rd_q, gbar_rd_q;
  logic [hhcn_pkg::COMP_AW-1:0] addr;
  logic [31:0]                 p1_q;
  logic [32:0]                 p2_q;
  logic [16:0]                 dvs;
  logic [hhcn_pkg::DIV_QW-1:0] s_q;
  logic [15:0]                 sc;
  logic [15:0]                 gate_q;
  logic [15:0]                 gsel;
  logic [31:0]                 prod_q;
  logic [17:0]                 gw;
  logic [15:0]                 g;
  logic [15:0]                 g_q;
  logic signed [17:0]          vd;
  logic signed [35:0]          cur_q;
  logic signed [31:0]          cur_sat;
  logic                        out_valid_q;
  logic                        load;
  hhcn_pkg::div_req_t          req;
  hhcn_pkg::div_rsp_t          rsp;

  hhcn_div u_div (.clk_i, .rst_ni, .req_i(req), .rsp_o(rsp));

  assign addr = job_q.comp[hhcn_pkg::COMP_AW-1:0];
  assign dvs = 17'h10000 + 17'(cfg_i.ratio);
  assign req.start = (state_q == B_SUM);
  assign req.dividend = hhcn_pkg::DIV_NW'({p1_q, 1'b0}) + hhcn_pkg::DIV_NW'(p2_q)
                        + hhcn_pkg::DIV_NW'(dvs >> 1);
  assign req.divisor = hhcn_pkg::DIV_DW'(dvs);

  assign sc = (s_q > hhcn_pkg::DIV_QW'(32768)) ? 16'd32768 : s_q[15:0];
  assign gsel = job_q.cmd ? gbar_rd_q : job_q.gbar;
  assign gw = 18'((33'(prod_q) + 33'd16384) >> 15);
  assign g = (gw > 18'd65535) ? 16'hFFFF : gw[15:0];
  assign vd = 18'(job_q.v) - 18'(cfg_i.erev);

  always_comb begin
    if (cur_q > 36'sd2147483647) cur_sat = 32'sh7FFF_FFFF;
    else if (cur_q < -36'sd2147483648) cur_sat = 32'sh8000_0000;
    else cur_sat = cur_q[31:0];
  end

  assign load = (state_q == B_SAT) && (!out_valid_q || out_chan.ready);
  assign pop_ready_o = (state_q == B_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE:  if (pop_valid_i) state_d = B_RD;
      B_RD:    state_d = job_q.cmd ? B_SUM : B_CLAMP;
      B_SUM:   state_d = B_DIV;
      B_DIV:   if (rsp.done) state_d = B_CLAMP;
      B_CLAMP: state_d = B_MUL;
      B_MUL:   state_d = B_SAT;
      B_SAT:   if (load) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) out_valid_q <= 1'b1;
      else if (out_chan.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == B_IDLE && pop_valid_i) begin
      job_q <= pop_job_i;
      gate_rd_q <= gate_mem[pop_job_i.comp[hhcn_pkg::COMP_AW-1:0]];
    end
    if (state_q == B_CLAMP) gate_mem[addr] <= sc;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == B_IDLE && pop_valid_i)
      gbar_rd_q <= gbar_mem[pop_job_i.comp[hhcn_pkg::COMP_AW-1:0]];
    if (state_q == B_RD && !job_q.cmd) gbar_mem[addr] <= job_q.gbar;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == B_RD) begin
      p1_q <= job_q.minf * cfg_i.ratio;
      p2_q <= (17'h10000 - 17'(cfg_i.ratio)) * 33'(gate_rd_q);
      if (!job_q.cmd) s_q <= hhcn_pkg::DIV_QW'(job_q.minf);
    end
    if (state_q == B_DIV && rsp.done) s_q <= rsp.quot;
    if (state_q == B_CLAMP) begin
      gate_q <= sc;
      prod_q <= gsel * sc;
    end
    if (state_q == B_MUL) begin
      g_q <= g;
      cur_q <= $signed({2'b0, g}) * vd;
    end
    if (load) begin
      out_chan.compartment_out <= job_q.comp;
      out_chan.gate_value <= gate_q;
      out_chan.conductance <= g_q;
      out_chan.channel_current <= cur_sat;
    end
  end

  assign out_chan.valid = out_valid_q;

endmodule
